// ===== design/shared_buffer_multi_queue_macros.svh =====
// Assertion macros for the shared buffer multi queue checker.
// Depends on nothing; included by the checker file.
`ifndef SHARED_BUFFER_MULTI_QUEUE_MACROS_SVH
`define SHARED_BUFFER_MULTI_QUEUE_MACROS_SVH

// Check cons in the same cycle as ante.
`define SBMQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbmq: same-cycle check failed");

// Check cons in the cycle after ante.
`define SBMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbmq: next-cycle check failed");

`endif

// ===== design/sbmq_pkg.sv =====
// Shared types and constants for the shared buffer multi queue.
// Depends on nothing; used by the top level and the checker.
package sbmq_pkg;

  localparam int QUEUE_ID_W = 3;
  localparam int DATA_W     = 32;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [QUEUE_ID_W-1:0]    queue_id_t;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  localparam data_t DATA_NONE = '1;

endpackage

// ===== design/sbmq_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module sbmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wen,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/shared_buffer_multi_queue.sv =====
// Steps: accept, queue table read, then link memory read or tail link write; a refused item
// or an enqueue into an empty queue finishes at the queue table read.
// One word is in flight at a time; the next word is taken the cycle after the result is
// registered. A result that finds the output still stalled is parked and holds the next
// word off until it moves out.
// Reset: all queues empty, free list in slot order, tracked by a fill count (no clearing pass).
module shared_buffer_multi_queue #(
  parameter int NUM_QUEUES = 8,
  parameter int CAPACITY   = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  sbmq_pkg::queue_id_t   queue_id,
  input  sbmq_pkg::data_t       value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  ok,
  output sbmq_pkg::data_t       data_out
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = AW + 1;
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [PW-1:0] PTR_NULL = PW'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state;
  logic                op;
  sbmq_pkg::queue_id_t qid;
  sbmq_pkg::data_t     val;
  logic [PW-1:0]       free_head;
  logic [PW-1:0]       fresh;
  logic [NUM_QUEUES-1:0] qvalid;
  logic [PW-1:0]       cur_head;
  logic [PW-1:0]       cur_tail;
  logic [PW-1:0]       slot;
  logic                res_ok;
  sbmq_pkg::data_t     res_data;

  logic                link_we;
  logic [AW-1:0]       link_waddr;
  logic [PW-1:0]       link_wdata;
  logic [AW-1:0]       link_raddr;
  logic [PW-1:0]       link_rdata;

  logic                data_we;
  logic [AW-1:0]       data_waddr;
  sbmq_pkg::data_t     data_wdata;
  logic [AW-1:0]       data_raddr;
  sbmq_pkg::data_t     data_rdata;

  logic                qtab_we;
  logic [QW-1:0]       qtab_waddr;
  logic [2*PW-1:0]     qtab_wdata;
  logic [QW-1:0]       qtab_raddr;
  logic [2*PW-1:0]     qtab_rdata;

  logic [31:0]         q_ext;
  logic [31:0]         q_in_ext;
  logic                q_in_range;
  logic [QW-1:0]       q_addr;
  logic [PW-1:0]       qh;
  logic [PW-1:0]       qt;
  logic                head_ok;
  logic                free_ok;
  logic                fresh_slot;
  logic [PW-1:0]       link_eff;
  logic                out_free;
  logic                out_load;
  logic                fin;
  logic                fin_ok;
  sbmq_pkg::data_t     fin_data;

  sbmq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .wen   (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  sbmq_ram #(.WIDTH(sbmq_pkg::DATA_W), .DEPTH(CAPACITY)) u_data_ram (
    .clk   (clk),
    .wen   (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  sbmq_ram #(.WIDTH(2 * PW), .DEPTH(NUM_QUEUES)) u_qtab_ram (
    .clk   (clk),
    .wen   (qtab_we),
    .waddr (qtab_waddr),
    .wdata (qtab_wdata),
    .raddr (qtab_raddr),
    .rdata (qtab_rdata)
  );

  assign q_ext      = 32'(qid);
  assign q_in_ext   = 32'(queue_id);
  assign q_in_range = q_ext < 32'(NUM_QUEUES);
  assign q_addr     = q_ext[QW-1:0];
  assign qtab_raddr = q_in_ext[QW-1:0];
  assign qtab_waddr = q_addr;

  assign qh         = qvalid[q_addr] ? qtab_rdata[2*PW-1:PW] : PTR_NULL;
  assign qt         = qvalid[q_addr] ? qtab_rdata[PW-1:0] : PTR_NULL;
  assign head_ok    = qh < PTR_NULL;
  assign free_ok    = free_head < PTR_NULL;
  assign fresh_slot = free_head >= fresh;
  assign link_eff   = fresh_slot ? (free_head + PW'(1)) : link_rdata;
  assign out_free   = !out_valid || !out_stall;
  assign out_load   = out_free && (fin || state == S_DONE);
  assign in_stall   = state != S_IDLE;

  always_comb begin
    fin        = 1'b0;
    fin_ok     = 1'b0;
    fin_data   = sbmq_pkg::DATA_NONE;
    link_we    = 1'b0;
    link_waddr = free_head[AW-1:0];
    link_wdata = PTR_NULL;
    link_raddr = free_head[AW-1:0];
    data_we    = 1'b0;
    data_waddr = free_head[AW-1:0];
    data_wdata = val;
    data_raddr = qh[AW-1:0];
    qtab_we    = 1'b0;
    qtab_wdata = {qh, free_head};
    unique case (state)
      S_IDLE: begin
      end
      S_LOOK: begin
        link_raddr = qh[AW-1:0];
        if (!q_in_range) begin
          fin = 1'b1;
        end else begin
          unique case (op)
            sbmq_pkg::ACT_ENQ: begin
              if (free_ok) begin
                data_we    = 1'b1;
                link_we    = 1'b1;
                qtab_we    = 1'b1;
                qtab_wdata = head_ok ? {qh, free_head} : {free_head, free_head};
                if (!head_ok) begin
                  fin    = 1'b1;
                  fin_ok = 1'b1;
                end
              end else begin
                fin = 1'b1;
              end
            end
            sbmq_pkg::ACT_DEQ: begin
              if (!head_ok) begin
                fin = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        link_we    = 1'b1;
        link_waddr = cur_head[AW-1:0];
        link_wdata = free_head;
        qtab_we    = 1'b1;
        qtab_wdata = {link_rdata, cur_tail};
        fin        = 1'b1;
        fin_ok     = 1'b1;
        fin_data   = data_rdata;
      end
      S_TAIL: begin
        link_we    = 1'b1;
        link_waddr = cur_tail[AW-1:0];
        link_wdata = slot;
        fin        = 1'b1;
        fin_ok     = 1'b1;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      fresh     <= '0;
      qvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= action;
            qid   <= queue_id;
            val   <= value;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          cur_head <= qh;
          cur_tail <= qt;
          slot     <= free_head;
          if (q_in_range && op == sbmq_pkg::ACT_ENQ && free_ok) begin
            free_head      <= link_eff;
            qvalid[q_addr] <= 1'b1;
            if (fresh_slot) begin
              fresh <= fresh + PW'(1);
            end
          end
          if (!fin) begin
            state <= (op == sbmq_pkg::ACT_ENQ) ? S_TAIL : S_POP;
          end
        end
        S_POP: begin
          free_head <= cur_head;
        end
        S_TAIL: begin
        end
        S_DONE: begin
          if (out_free) begin
            ok       <= res_ok;
            data_out <= res_data;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (fin) begin
        if (out_free) begin
          ok       <= fin_ok;
          data_out <= fin_data;
          state    <= S_IDLE;
        end else begin
          res_ok   <= fin_ok;
          res_data <= fin_data;
          state    <= S_DONE;
        end
      end
    end
  end

endmodule

// ===== design/sbmq_checker.sv =====
// Port-level checks for the shared buffer multi queue, bound to the top level.
// Depends on sbmq_pkg and shared_buffer_multi_queue_macros.svh.
`include "shared_buffer_multi_queue_macros.svh"

module sbmq_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic            ok,
  input sbmq_pkg::data_t data_out
);

  `SBMQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `SBMQ_ASSERT_NOW(a_fail_data_none, clk, rst, out_valid && !ok, data_out == sbmq_pkg::DATA_NONE)
  `SBMQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(ok) && $stable(data_out))
  `SBMQ_ASSERT_NOW(a_idle_after_reset, clk, rst, $past(rst), !out_valid && !in_stall)

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (.*);
